// File: rtl/rbwl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwl_pkg
// Shared types and constants of the restart backoff window limiter: event and
// action codes, register indexes, beat structs and controller interface.
// ----------------------------------------------------------------------------
package rbwl_pkg;

  // Width of the configuration register index; leaves room for unused indexes.
  localparam int CfgIdxW = 4;
  localparam int CfgDataW = 32;
  localparam int TimeW = 48;
  localparam int DelayW = 32;
  localparam int ConsecW = 16;
  localparam int WinCntW = 5;
  localparam int MaxFailW = 5;
  localparam int LevelsW = 3;
  localparam int MaxBackoff = 4;

  // Register reset values.
  localparam logic [MaxFailW-1:0] MaxFailRst = 5'd5;
  localparam logic [DelayW-1:0] WindowRst = 32'd60000;
  localparam logic AutoRst = 1'b1;
  localparam logic [LevelsW-1:0] LevelsRst = 3'd4;
  localparam logic [MaxBackoff-1:0][DelayW-1:0] BackoffRst = {
    32'd10000, 32'd5000, 32'd2000, 32'd1000
  };

  // Event kinds.
  typedef enum logic [1:0] {
    FUNC_START_OK   = 2'd0,
    FUNC_START_FAIL = 2'd1,
    FUNC_EXITED     = 2'd2,
    FUNC_STOP       = 2'd3
  } func_e;

  // Result actions.
  typedef enum logic [2:0] {
    ACT_IGNORED    = 3'd0,
    ACT_READY      = 3'd1,
    ACT_GAVE_UP    = 3'd2,
    ACT_NO_RESTART = 3'd3,
    ACT_RESTART    = 3'd4,
    ACT_STOPPED    = 3'd5
  } action_e;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    CFG_MAX_FAIL = 4'd0,
    CFG_WINDOW   = 4'd1,
    CFG_AUTO     = 4'd2,
    CFG_LEVELS   = 4'd3,
    CFG_DELAY_0  = 4'd4,
    CFG_DELAY_1  = 4'd5,
    CFG_DELAY_2  = 4'd6,
    CFG_DELAY_3  = 4'd7
  } cfg_idx_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_PRUNE_RD,
    ST_PRUNE_CMP,
    ST_PUSH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    func_e             func;
    logic [TimeW-1:0]  now_ms;
  } in_beat_t;

  typedef struct packed {
    action_e             action;
    logic [DelayW-1:0]   delay_ms;
    logic [ConsecW-1:0]  consecutive_count;
    logic [WinCntW-1:0]  window_count;
  } out_beat_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_in;
    logic decide;
    logic pop;
    logic push;
    logic load_out;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic count_fail;
    logic fill_zero;
    logic stale;
  } dp_sts_t;

endpackage
`default_nettype wire

// File: rtl/rbwl_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwl_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rbwl_ram #(
  parameter int Width = 48,
  parameter int Depth = 16
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                      wdata_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/rbwl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwl_ctrl
// Sequencer of the limiter: accepts one event beat, for a counted failure walks the
// window pruning loop over the timestamp memory, then hands the result to the output stage.
// ----------------------------------------------------------------------------
module rbwl_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output rbwl_pkg::dp_cmd_t      cmd_o,
  input  wire rbwl_pkg::dp_sts_t sts_i
);

  rbwl_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_busy;

  assign out_busy    = out_valid_q && out_stall_i;
  assign out_valid_o = out_valid_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rbwl_pkg::ST_IDLE: begin
        if (in_valid_i) state_d = rbwl_pkg::ST_DECIDE;
      end
      rbwl_pkg::ST_DECIDE: begin
        state_d = sts_i.count_fail ? rbwl_pkg::ST_PRUNE_RD : rbwl_pkg::ST_FINISH;
      end
      rbwl_pkg::ST_PRUNE_RD: begin
        state_d = sts_i.fill_zero ? rbwl_pkg::ST_PUSH : rbwl_pkg::ST_PRUNE_CMP;
      end
      rbwl_pkg::ST_PRUNE_CMP: begin
        state_d = sts_i.stale ? rbwl_pkg::ST_PRUNE_RD : rbwl_pkg::ST_PUSH;
      end
      rbwl_pkg::ST_PUSH: begin
        state_d = rbwl_pkg::ST_FINISH;
      end
      rbwl_pkg::ST_FINISH: begin
        if (!out_busy) state_d = rbwl_pkg::ST_IDLE;
      end
      default: state_d = rbwl_pkg::ST_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      rbwl_pkg::ST_IDLE: begin
        in_stall_o    = 1'b0;
        cmd_o.load_in = in_valid_i;
      end
      rbwl_pkg::ST_DECIDE:    cmd_o.decide = 1'b1;
      rbwl_pkg::ST_PRUNE_RD:  cmd_o = '0;
      rbwl_pkg::ST_PRUNE_CMP: cmd_o.pop = sts_i.stale;
      rbwl_pkg::ST_PUSH:      cmd_o.push = 1'b1;
      rbwl_pkg::ST_FINISH:    cmd_o.load_out = !out_busy;
      default:                cmd_o = '0;
    endcase
  end

  // The output slot fills on a load and empties when its beat is taken.
  assign out_valid_d = cmd_o.load_out || out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rbwl_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // A result must never overwrite a beat that is still waiting downstream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> !(out_valid_q && out_stall_i))
    else $error("result loaded over a stalled output beat");

  // An accepted event always starts with the decision step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == rbwl_pkg::ST_DECIDE))
    else $error("accepted event did not enter the decision step");

  // A stalled result beat stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result beat was withdrawn");

endmodule
`default_nettype wire

// File: rtl/rbwl_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbwl_dp
// Datapath of the limiter: configuration registers, supervisor flags, the
// consecutive failure counter, the timestamp ring and the result registers.
// ----------------------------------------------------------------------------
module rbwl_dp #(
  parameter int WINDOW_DEPTH = 16,
  parameter int BACKOFF_ENTRIES = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  input  wire logic [rbwl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rbwl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire rbwl_pkg::in_beat_t             in_data_i,
  output rbwl_pkg::out_beat_t                 out_data_o,
  input  wire rbwl_pkg::dp_cmd_t              cmd_i,
  output rbwl_pkg::dp_sts_t                   sts_o
);

  localparam int IdxW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int CntW = $clog2(WINDOW_DEPTH + 1);
  localparam int SumW = CntW + 1;
  localparam int CmpW = rbwl_pkg::TimeW + 1;

  // Configuration registers.
  logic [rbwl_pkg::MaxFailW-1:0] max_fail_q;
  logic [rbwl_pkg::DelayW-1:0]   window_q;
  logic                          auto_q;
  logic [rbwl_pkg::LevelsW-1:0]  levels_q;
  logic [rbwl_pkg::DelayW-1:0]   delay_q [BACKOFF_ENTRIES];

  // Event and supervisor state.
  rbwl_pkg::func_e               func_q;
  logic [rbwl_pkg::TimeW-1:0]    now_q;
  logic                          stopped_q;
  logic                          given_up_q;
  logic                          active_q;
  logic [rbwl_pkg::ConsecW-1:0]  consec_q;
  logic [IdxW-1:0]               head_q;
  logic [CntW-1:0]               fill_q;
  rbwl_pkg::action_e             res_act_q;
  logic [rbwl_pkg::DelayW-1:0]   res_delay_q;
  rbwl_pkg::out_beat_t           out_q;

  // Register write decode.
  logic we_max, we_win, we_auto, we_lvl, we_dly;

  always_comb begin
    we_max  = 1'b0;
    we_win  = 1'b0;
    we_auto = 1'b0;
    we_lvl  = 1'b0;
    we_dly  = 1'b0;
    unique case (cfg_index_i) inside
      rbwl_pkg::CFG_MAX_FAIL: we_max  = cfg_valid_i;
      rbwl_pkg::CFG_WINDOW:   we_win  = cfg_valid_i;
      rbwl_pkg::CFG_AUTO:     we_auto = cfg_valid_i;
      rbwl_pkg::CFG_LEVELS:   we_lvl  = cfg_valid_i;
      rbwl_pkg::CFG_DELAY_0, rbwl_pkg::CFG_DELAY_1,
      rbwl_pkg::CFG_DELAY_2, rbwl_pkg::CFG_DELAY_3: we_dly = cfg_valid_i;
      default: we_dly = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_fail_q <= rbwl_pkg::MaxFailRst;
      window_q   <= rbwl_pkg::WindowRst;
      auto_q     <= rbwl_pkg::AutoRst;
      levels_q   <= rbwl_pkg::LevelsRst;
    end else begin
      if (we_max)  max_fail_q <= cfg_data_i[rbwl_pkg::MaxFailW-1:0];
      if (we_win)  window_q   <= cfg_data_i;
      if (we_auto) auto_q     <= cfg_data_i[0];
      if (we_lvl)  levels_q   <= cfg_data_i[rbwl_pkg::LevelsW-1:0];
    end
  end

  // Backoff delay table; only the entries that can be selected are kept.
  for (genvar k = 0; k < BACKOFF_ENTRIES; k++) begin : g_delay
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        delay_q[k] <= rbwl_pkg::BackoffRst[k];
      end else if (we_dly && (cfg_index_i[1:0] == 2'(k))) begin
        delay_q[k] <= cfg_data_i;
      end
    end
  end

  // A failure is counted for a failed start, or an exit of an active attempt, unless stopped or given up.
  logic terminal;
  logic count_fail;

  assign terminal   = stopped_q || given_up_q;
  assign count_fail = !terminal &&
                      ((func_q == rbwl_pkg::FUNC_START_FAIL) ||
                       ((func_q == rbwl_pkg::FUNC_EXITED) && active_q));

  // Oldest timestamp plus the window, against the event time.
  logic [rbwl_pkg::TimeW-1:0] rd_time;
  logic [CmpW-1:0]            limit;

  assign limit = CmpW'(rd_time) + CmpW'(window_q);

  assign sts_o.count_fail = count_fail;
  assign sts_o.fill_zero  = (fill_q == '0);
  assign sts_o.stale      = limit < CmpW'(now_q);

  // Push: drop the oldest entry of a full ring, then append at the tail.
  logic            full;
  logic [IdxW-1:0] head_inc;
  logic [IdxW-1:0] head_a;
  logic [CntW-1:0] fill_a;
  logic [CntW-1:0] fill_n;
  logic [SumW-1:0] tail_sum;
  logic [IdxW-1:0] tail;
  logic            gave_up;

  assign head_inc = (head_q == IdxW'(WINDOW_DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign full     = (fill_q == CntW'(WINDOW_DEPTH));
  assign head_a   = full ? head_inc : head_q;
  assign fill_a   = full ? CntW'(WINDOW_DEPTH - 1) : fill_q;
  assign fill_n   = fill_a + 1'b1;

  always_comb begin
    tail_sum = SumW'(head_a) + SumW'(fill_a);
    if (tail_sum >= SumW'(WINDOW_DEPTH)) begin
      tail_sum = tail_sum - SumW'(WINDOW_DEPTH);
    end
  end

  assign tail    = IdxW'(tail_sum);
  assign gave_up = 32'(fill_n) >= 32'(max_fail_q);

  // Backoff entry: count minus one, clamped to the last usable level.
  logic [rbwl_pkg::LevelsW-1:0] levels;
  logic [rbwl_pkg::ConsecW-1:0] sel;
  logic [rbwl_pkg::DelayW-1:0]  pick;

  always_comb begin
    levels = (32'(levels_q) > BACKOFF_ENTRIES) ?
             rbwl_pkg::LevelsW'(BACKOFF_ENTRIES) : levels_q;
    sel    = (consec_q == '0) ? '0 : consec_q - 1'b1;
    if (sel > rbwl_pkg::ConsecW'(levels) - 1'b1) begin
      sel = rbwl_pkg::ConsecW'(levels) - 1'b1;
    end
    pick = '0;
    for (int k = 0; k < BACKOFF_ENTRIES; k++) begin
      if (sel == rbwl_pkg::ConsecW'(k)) pick = delay_q[k];
    end
    if (levels == '0) pick = '0;
  end

  // Timestamp ring; the read port follows the head.
  rbwl_ram #(
    .Width (rbwl_pkg::TimeW),
    .Depth (WINDOW_DEPTH)
  ) u_times (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push),
    .waddr_i (tail),
    .wdata_i (now_q),
    .raddr_i (head_q),
    .rdata_o (rd_time)
  );

  // Event capture, payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      func_q <= in_data_i.func;
      now_q  <= in_data_i.now_ms;
    end
  end

  // Supervisor state and ring pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stopped_q  <= 1'b0;
      given_up_q <= 1'b0;
      active_q   <= 1'b0;
      consec_q   <= '0;
      head_q     <= '0;
      fill_q     <= '0;
    end else begin
      if (cmd_i.decide) begin
        if (func_q == rbwl_pkg::FUNC_STOP) begin
          stopped_q <= 1'b1;
        end else if (!terminal && (func_q == rbwl_pkg::FUNC_START_OK)) begin
          active_q <= 1'b1;
          consec_q <= '0;
        end else if (count_fail) begin
          active_q <= 1'b0;
          if (consec_q != '1) consec_q <= consec_q + 1'b1;
        end
      end
      if (cmd_i.pop) begin
        head_q <= head_inc;
        fill_q <= fill_q - 1'b1;
      end
      if (cmd_i.push) begin
        head_q <= head_a;
        fill_q <= fill_n;
        if (gave_up) given_up_q <= 1'b1;
      end
    end
  end

  // Result registers, payload only.
  always_ff @(posedge clk_i) begin
    if (cmd_i.decide && !count_fail) begin
      res_delay_q <= '0;
      if (func_q == rbwl_pkg::FUNC_STOP) begin
        res_act_q <= rbwl_pkg::ACT_STOPPED;
      end else if (!terminal && (func_q == rbwl_pkg::FUNC_START_OK)) begin
        res_act_q <= rbwl_pkg::ACT_READY;
      end else begin
        res_act_q <= rbwl_pkg::ACT_IGNORED;
      end
    end
    if (cmd_i.push) begin
      if (gave_up) begin
        res_act_q   <= rbwl_pkg::ACT_GAVE_UP;
        res_delay_q <= '0;
      end else if (!auto_q) begin
        res_act_q   <= rbwl_pkg::ACT_NO_RESTART;
        res_delay_q <= '0;
      end else begin
        res_act_q   <= rbwl_pkg::ACT_RESTART;
        res_delay_q <= pick;
      end
    end
    if (cmd_i.load_out) begin
      out_q.action            <= res_act_q;
      out_q.delay_ms          <= res_delay_q;
      out_q.consecutive_count <= consec_q;
      out_q.window_count      <= rbwl_pkg::WinCntW'(32'(fill_q));
    end
  end

  assign out_data_o = out_q;

  // The ring never holds more timestamps than it has entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fill_q) <= WINDOW_DEPTH)
    else $error("window fill exceeds ring depth");

  // A prune step only drops an entry that exists.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.pop |-> (fill_q != '0))
    else $error("pop from an empty window");

  // Giving up is permanent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(given_up_q) |-> given_up_q)
    else $error("given-up state was cleared");

endmodule
`default_nettype wire

// File: rtl/restart_backoff_window_limiter_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Restart supervisor with backoff and a sliding-window failure limit. Each
// input beat is one event (start ok, start failed, process exited, stop) with
// a millisecond timestamp, and each gives exactly one result beat. Events are
// handled one at a time. An event that counts no failure goes from the
// decision step straight to the result; a counted failure first prunes stale
// timestamps from the window, then pushes its own timestamp. The pruning loop
// reads the oldest timestamp through the single registered read port of the
// timestamp memory and compares it before the next one can be read. A new
// event is taken while a finished result still waits in the output register.
// Configuration registers are written through their own port, which is always
// ready; the user must write them only while no event is in flight, and the
// block itself does not enforce this.
// ----------------------------------------------------------------------------
// restart_backoff_window_limiter_unit
// Top level: joins the sequencer and the datapath of the restart limiter.
// ----------------------------------------------------------------------------
module restart_backoff_window_limiter_unit #(
  parameter int WINDOW_DEPTH = 16,
  parameter int BACKOFF_ENTRIES = 4
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [rbwl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [rbwl_pkg::CfgDataW-1:0]  cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire rbwl_pkg::in_beat_t             in_data_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output rbwl_pkg::out_beat_t                 out_data_o
);

  rbwl_pkg::dp_cmd_t cmd;
  rbwl_pkg::dp_sts_t sts;

  // Register writes are always accepted.
  assign cfg_ready_o = 1'b1;

  rbwl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  rbwl_dp #(
    .WINDOW_DEPTH    (WINDOW_DEPTH),
    .BACKOFF_ENTRIES (BACKOFF_ENTRIES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule
`default_nettype wire
